>>> rtl/core/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, constants and 32-bit wrapping arithmetic helpers for the
// environmental sensor compensation pipeline.
// ----------------------------------------------------------------------------
package esc_pkg;

   localparam int DIV_W       = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 48;
   localparam int HUM_W       = 14;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TEMP_CAL    = 3'd0,
      REG_PRESS_CAL_A = 3'd1,
      REG_PRESS_CAL_B = 3'd2,
      REG_PRESS_CAL_C = 3'd3,
      REG_HUM_CAL_A   = 3'd4,
      REG_HUM_CAL_B   = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [47:0] temp_cal;
      logic [47:0] press_cal_a;
      logic [47:0] press_cal_b;
      logic [47:0] press_cal_c;
      logic [31:0] hum_cal_a;
      logic [31:0] hum_cal_b;
   } cal_type;

   // values that ride alongside the divider
   typedef struct packed {
      logic [31:0]      temp;
      logic [HUM_W-1:0] hum;
      logic             pvalid;
      logic             big;
   } side_type;

   localparam logic [31:0] T_FINE_OFS  = 32'd64000;
   localparam logic [31:0] H_FINE_OFS  = 32'd76800;
   localparam logic [31:0] H_CLAMP     = 32'd419430400;
   localparam logic [31:0] P_SCALE     = 32'd3125;
   localparam logic [31:0] P_BASE      = 32'd1048576;
   localparam logic [31:0] H_BIAS_C    = 32'd2097152;
   localparam logic [31:0] P_HALF      = 32'd32768;
   localparam logic [31:0] H_RND_B     = 32'd16384;
   localparam logic [31:0] H_RND_E     = 32'd8192;
   localparam logic [31:0] T_RND       = 32'd128;

   function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = a * b;
      return p[31:0];
   endfunction

   function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] n);
      return $unsigned($signed(v) >>> n);
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] sx12(input logic [11:0] v);
      return {{20{v[11]}}, v};
   endfunction

   function automatic logic [31:0] sx8(input logic [7:0] v);
      return {{24{v[7]}}, v};
   endfunction

endpackage

>>> rtl/core/esc_csr.sv
// ----------------------------------------------------------------------------
// esc_csr
// Calibration register file, written through a valid/ready port.
// ----------------------------------------------------------------------------
module esc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [esc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [esc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output esc_pkg::cal_type               cal
);

   esc_pkg::cal_type cal_ff;

   assign csr_ready = 1'b1;
   assign cal       = cal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            esc_pkg::REG_TEMP_CAL:    cal_ff.temp_cal    <= csr_wdata;
            esc_pkg::REG_PRESS_CAL_A: cal_ff.press_cal_a <= csr_wdata;
            esc_pkg::REG_PRESS_CAL_B: cal_ff.press_cal_b <= csr_wdata;
            esc_pkg::REG_PRESS_CAL_C: cal_ff.press_cal_c <= csr_wdata;
            esc_pkg::REG_HUM_CAL_A:   cal_ff.hum_cal_a   <= csr_wdata[31:0];
            esc_pkg::REG_HUM_CAL_B:   cal_ff.hum_cal_b   <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

endmodule

>>> rtl/core/esc_front.sv
// ----------------------------------------------------------------------------
// esc_front
// Thirteen-stage pipeline: fine temperature, temperature, pressure divide
// operands and the complete humidity result.
// ----------------------------------------------------------------------------
module esc_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  esc_pkg::cal_type            cal,
   input  logic                        in_valid,
   input  logic [19:0]                 in_ut,
   input  logic [19:0]                 in_up,
   input  logic [15:0]                 in_uh,
   output logic                        out_valid,
   output logic [31:0]                 out_dividend,
   output logic [31:0]                 out_divisor,
   output esc_pkg::side_type           out_side
);

   localparam int STAGES = 13;

   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, h1, h2, h3, h4, h5, h6;

   always_comb begin
      t1 = {16'd0, cal.temp_cal[15:0]};
      t2 = esc_pkg::sx16(cal.temp_cal[31:16]);
      t3 = esc_pkg::sx16(cal.temp_cal[47:32]);
      p1 = {16'd0, cal.press_cal_a[15:0]};
      p2 = esc_pkg::sx16(cal.press_cal_a[31:16]);
      p3 = esc_pkg::sx16(cal.press_cal_a[47:32]);
      p4 = esc_pkg::sx16(cal.press_cal_b[15:0]);
      p5 = esc_pkg::sx16(cal.press_cal_b[31:16]);
      p6 = esc_pkg::sx16(cal.press_cal_b[47:32]);
      h1 = {24'd0, cal.hum_cal_a[7:0]};
      h2 = esc_pkg::sx16(cal.hum_cal_a[23:8]);
      h3 = {24'd0, cal.hum_cal_a[31:24]};
      h4 = esc_pkg::sx12(cal.hum_cal_b[11:0]);
      h5 = esc_pkg::sx12(cal.hum_cal_b[23:12]);
      h6 = esc_pkg::sx8(cal.hum_cal_b[31:24]);
   end

   logic [STAGES-1:0] vld_ff;

   // stage registers
   logic [31:0] x1_ff, td1_ff, m2_ff, dd2_ff, a3_ff, m3_ff, fine4_ff;
   logic [31:0] temp5_ff, pa5_ff, ah5_ff;
   logic [31:0] temp6_ff, d6_ff, m5_6_ff, mp2_6_ff, mh5_6_ff, m6_6_ff, m3_6_ff;
   logic [31:0] temp7_ff, b7_ff, c7_ff, m5_7_ff, mp2_7_ff, hb7_ff, cp7_ff;
   logic [31:0] temp8_ff, bb8_ff, sum8_ff, hb8_ff, mc8_ff;
   logic [31:0] temp9_ff, prod9_ff, num9_ff, ha9_ff;
   logic [31:0] temp10_ff, dvs10_ff, dvd10_ff, ha10_ff, ss10_ff;
   logic        big10_ff, pv10_ff;
   logic [31:0] temp11_ff, dvs11_ff, dvd11_ff, ha11_ff, dm11_ff;
   logic        big11_ff, pv11_ff;
   logic [31:0] temp12_ff, dvs12_ff, dvd12_ff;
   logic        big12_ff, pv12_ff;
   logic [16:0] hq12_ff;
   logic [31:0] temp13_ff, dvs13_ff, dvd13_ff;
   logic        big13_ff, pv13_ff;
   logic [esc_pkg::HUM_W-1:0] hum13_ff;
   logic [19:0] up1_ff, up2_ff, up3_ff, up4_ff, up5_ff, up6_ff, up7_ff, up8_ff;
   logic [15:0] uh1_ff, uh2_ff, uh3_ff, uh4_ff, uh5_ff, uh6_ff;

   // next values
   logic [31:0] x1_in, td1_in, m2_in, dd2_in, a3_in, m3_in, fine4_in;
   logic [31:0] temp5_in, pa5_in, ah5_in;
   logic [31:0] d6_in, m5_6_in, mp2_6_in, mh5_6_in, m6_6_in, m3_6_in;
   logic [31:0] b7_in, c7_in, hb7_in, cp7_in;
   logic [31:0] bb8_in, sum8_in, mc8_in;
   logic [31:0] prod9_in, num9_in, ha9_in;
   logic [31:0] dvs10_in, dvd10_in, ss10_in;
   logic        big10_in, pv10_in;
   logic [31:0] dm11_in;
   logic [16:0] hq12_in;
   logic [esc_pkg::HUM_W-1:0] hum13_in;

   logic [31:0] q6, hh8, he9, a12;
   logic [6:0]  hi13;
   logic [19:0] lo13;
   logic [17:0] fr13;

   always_comb begin
      x1_in    = ({12'd0, in_ut} >> 3) - (t1 << 1);
      td1_in   = ({12'd0, in_ut} >> 4) - t1;
      m2_in    = esc_pkg::mul32(x1_ff, t2);
      dd2_in   = esc_pkg::mul32(td1_ff, td1_ff);
      a3_in    = esc_pkg::asr32(m2_ff, 5'd11);
      m3_in    = esc_pkg::mul32(esc_pkg::asr32(dd2_ff, 5'd12), t3);
      fine4_in = a3_ff + esc_pkg::asr32(m3_ff, 5'd14);
      // times five by shift and add
      temp5_in = esc_pkg::asr32((fine4_ff << 2) + fine4_ff + esc_pkg::T_RND, 5'd8);
      pa5_in   = esc_pkg::asr32(fine4_ff, 5'd1) - esc_pkg::T_FINE_OFS;
      ah5_in   = fine4_ff - esc_pkg::H_FINE_OFS;
      q6       = esc_pkg::asr32(pa5_ff, 5'd2);
      d6_in    = esc_pkg::mul32(q6, q6);
      m5_6_in  = esc_pkg::mul32(pa5_ff, p5);
      mp2_6_in = esc_pkg::mul32(p2, pa5_ff);
      mh5_6_in = esc_pkg::mul32(h5, ah5_ff);
      m6_6_in  = esc_pkg::mul32(ah5_ff, h6);
      m3_6_in  = esc_pkg::mul32(ah5_ff, h3);
      b7_in    = esc_pkg::mul32(esc_pkg::asr32(d6_ff, 5'd11), p6);
      c7_in    = esc_pkg::mul32(p3, esc_pkg::asr32(d6_ff, 5'd13));
      hb7_in   = esc_pkg::asr32(({16'd0, uh6_ff} << 14) - (h4 << 20) - mh5_6_ff
                                + esc_pkg::H_RND_B, 5'd15);
      cp7_in   = esc_pkg::mul32(esc_pkg::asr32(m6_6_ff, 5'd10),
                                esc_pkg::asr32(m3_6_ff, 5'd11) + esc_pkg::P_HALF);
      bb8_in   = esc_pkg::asr32(b7_ff + (m5_7_ff << 1), 5'd2) + (p4 << 16);
      sum8_in  = esc_pkg::asr32(esc_pkg::asr32(c7_ff, 5'd3)
                                + esc_pkg::asr32(mp2_7_ff, 5'd1), 5'd18) + esc_pkg::P_HALF;
      hh8      = esc_pkg::asr32(cp7_ff, 5'd10) + esc_pkg::H_BIAS_C;
      mc8_in   = esc_pkg::mul32(hh8, h2);
      prod9_in = esc_pkg::mul32(sum8_ff, p1);
      num9_in  = esc_pkg::mul32((esc_pkg::P_BASE - {12'd0, up8_ff})
                                - esc_pkg::asr32(bb8_ff, 5'd12), esc_pkg::P_SCALE);
      he9      = esc_pkg::asr32(mc8_ff + esc_pkg::H_RND_E, 5'd14);
      ha9_in   = esc_pkg::mul32(hb8_ff, he9);
      dvs10_in = esc_pkg::asr32(prod9_ff, 5'd15);
      pv10_in  = (dvs10_in != 32'd0);
      big10_in = num9_ff[31];
      dvd10_in = big10_in ? num9_ff : (num9_ff << 1);
      ss10_in  = esc_pkg::mul32(esc_pkg::asr32(ha9_ff, 5'd15),
                                esc_pkg::asr32(ha9_ff, 5'd15));
      dm11_in  = esc_pkg::mul32(esc_pkg::asr32(ss10_ff, 5'd7), h1);
      a12      = ha11_ff - esc_pkg::asr32(dm11_ff, 5'd4);
      // clamp to 0 .. 100 %rH in Q10.22
      if (a12[31]) begin
         a12 = 32'd0;
      end else if (a12 > esc_pkg::H_CLAMP) begin
         a12 = esc_pkg::H_CLAMP;
      end
      hq12_in  = a12[28:12];
      hi13     = hq12_ff[16:10];
      lo13     = 20'({10'd0, hq12_ff[9:0]} * 20'd1000) >> 10;
      // divide by ten through a reciprocal, exact below 1024
      fr13     = 18'(lo13[9:0] * 18'd205) >> 11;
      hum13_in = 14'(hi13 * 14'd100) + {7'd0, fr13[6:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff <= x1_in;       td1_ff <= td1_in;     up1_ff <= in_up;     uh1_ff <= in_uh;
         m2_ff <= m2_in;       dd2_ff <= dd2_in;     up2_ff <= up1_ff;    uh2_ff <= uh1_ff;
         a3_ff <= a3_in;       m3_ff <= m3_in;       up3_ff <= up2_ff;    uh3_ff <= uh2_ff;
         fine4_ff <= fine4_in; up4_ff <= up3_ff;     uh4_ff <= uh3_ff;
         temp5_ff <= temp5_in; pa5_ff <= pa5_in;     ah5_ff <= ah5_in;
         up5_ff <= up4_ff;     uh5_ff <= uh4_ff;
         temp6_ff <= temp5_ff; d6_ff <= d6_in;       m5_6_ff <= m5_6_in;
         mp2_6_ff <= mp2_6_in; mh5_6_ff <= mh5_6_in; m6_6_ff <= m6_6_in;
         m3_6_ff <= m3_6_in;   up6_ff <= up5_ff;     uh6_ff <= uh5_ff;
         temp7_ff <= temp6_ff; b7_ff <= b7_in;       c7_ff <= c7_in;
         m5_7_ff <= m5_6_ff;   mp2_7_ff <= mp2_6_ff; hb7_ff <= hb7_in;
         cp7_ff <= cp7_in;     up7_ff <= up6_ff;
         temp8_ff <= temp7_ff; bb8_ff <= bb8_in;     sum8_ff <= sum8_in;
         hb8_ff <= hb7_ff;     mc8_ff <= mc8_in;     up8_ff <= up7_ff;
         temp9_ff <= temp8_ff; prod9_ff <= prod9_in; num9_ff <= num9_in;
         ha9_ff <= ha9_in;
         temp10_ff <= temp9_ff; dvs10_ff <= dvs10_in; dvd10_ff <= dvd10_in;
         big10_ff <= big10_in;  pv10_ff <= pv10_in;   ha10_ff <= ha9_ff;
         ss10_ff <= ss10_in;
         temp11_ff <= temp10_ff; dvs11_ff <= dvs10_ff; dvd11_ff <= dvd10_ff;
         big11_ff <= big10_ff;   pv11_ff <= pv10_ff;   ha11_ff <= ha10_ff;
         dm11_ff <= dm11_in;
         temp12_ff <= temp11_ff; dvs12_ff <= dvs11_ff; dvd12_ff <= dvd11_ff;
         big12_ff <= big11_ff;   pv12_ff <= pv11_ff;   hq12_ff <= hq12_in;
         temp13_ff <= temp12_ff; dvs13_ff <= dvs12_ff; dvd13_ff <= dvd12_ff;
         big13_ff <= big12_ff;   pv13_ff <= pv12_ff;   hum13_ff <= hum13_in;
      end
   end

   assign out_valid       = vld_ff[STAGES-1];
   assign out_dividend    = dvd13_ff;
   assign out_divisor     = dvs13_ff;
   assign out_side.temp   = temp13_ff;
   assign out_side.hum    = hum13_ff;
   assign out_side.pvalid = pv13_ff;
   assign out_side.big    = big13_ff;

endmodule

>>> rtl/core/esc_div.sv
// ----------------------------------------------------------------------------
// esc_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module esc_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic [esc_pkg::DIV_W-1:0]      in_dividend,
   input  logic [esc_pkg::DIV_W-1:0]      in_divisor,
   input  esc_pkg::side_type              in_side,
   output logic                           out_valid,
   output logic [esc_pkg::DIV_W-1:0]      out_quotient,
   output esc_pkg::side_type              out_side
);

   localparam int W = esc_pkg::DIV_W;

   logic             vld_ff  [W];
   logic [W-1:0]     rem_ff  [W];
   logic [W-1:0]     dq_ff   [W];
   logic [W-1:0]     dvs_ff  [W];
   esc_pkg::side_type side_ff [W];

   for (genvar k = 0; k < W; k++) begin : g_stage
      logic              v_prev;
      logic [W-1:0]      rem_prev, dq_prev, dvs_prev;
      esc_pkg::side_type side_prev;
      logic [W:0]        trial;
      logic              ge;
      logic [W-1:0]      rem_in, dq_in;

      if (k == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = '0;
         assign dq_prev   = in_dividend;
         assign dvs_prev  = in_divisor;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = vld_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign dq_prev   = dq_ff[k-1];
         assign dvs_prev  = dvs_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      // shift in the next dividend bit, subtract when it fits
      always_comb begin
         trial  = {rem_prev, dq_prev[W-1]};
         ge     = (trial >= {1'b0, dvs_prev});
         rem_in = ge ? W'(trial - {1'b0, dvs_prev}) : trial[W-1:0];
         dq_in  = {dq_prev[W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            dq_ff[k]   <= dq_in;
            dvs_ff[k]  <= dvs_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid    = vld_ff[W-1];
   assign out_quotient = dq_ff[W-1];
   assign out_side     = side_ff[W-1];

endmodule

>>> rtl/core/esc_back.sv
// ----------------------------------------------------------------------------
// esc_back
// Pressure correction after the divide and the result register.
// ----------------------------------------------------------------------------
module esc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  esc_pkg::cal_type            cal,
   input  logic                        in_valid,
   input  logic [31:0]                 in_quotient,
   input  esc_pkg::side_type           in_side,
   output logic                        out_valid,
   output logic signed [31:0]          out_temperature_centi,
   output logic [31:0]                 out_pressure_pa,
   output logic                        out_pressure_valid,
   output logic [esc_pkg::HUM_W-1:0]   out_humidity_centi
);

   logic [31:0] p7, p8, p9;

   logic [2:0]        vld_ff;
   logic [31:0]       pr1_ff, s2_1_ff, m8_1_ff, pr2_ff, c2_ff, d2_ff, pa3_ff;
   esc_pkg::side_type sd1_ff, sd2_ff, sd3_ff;

   logic [31:0] pr1_in, s2_1_in, m8_1_in, c2_in, d2_in, pa3_in, s1;

   always_comb begin
      p7      = esc_pkg::sx16(cal.press_cal_c[15:0]);
      p8      = esc_pkg::sx16(cal.press_cal_c[31:16]);
      p9      = esc_pkg::sx16(cal.press_cal_c[47:32]);
      // large numerator was divided unshifted: double the quotient
      pr1_in  = in_side.big ? (in_quotient << 1) : in_quotient;
      s1      = pr1_in >> 3;
      s2_1_in = esc_pkg::mul32(s1, s1);
      m8_1_in = esc_pkg::mul32(pr1_in >> 2, p8);
      c2_in   = esc_pkg::asr32(esc_pkg::mul32(p9, s2_1_ff >> 13), 5'd12);
      d2_in   = esc_pkg::asr32(m8_1_ff, 5'd13);
      pa3_in  = sd2_ff.pvalid ? pr2_ff + esc_pkg::asr32(c2_ff + d2_ff + p7, 5'd4) : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pr1_ff  <= pr1_in;  s2_1_ff <= s2_1_in; m8_1_ff <= m8_1_in; sd1_ff <= in_side;
         pr2_ff  <= pr1_ff;  c2_ff   <= c2_in;   d2_ff   <= d2_in;   sd2_ff <= sd1_ff;
         pa3_ff  <= pa3_in;  sd3_ff  <= sd2_ff;
      end
   end

   assign out_valid             = vld_ff[2];
   assign out_temperature_centi = $signed(sd3_ff.temp);
   assign out_pressure_pa       = pa3_ff;
   assign out_pressure_valid    = sd3_ff.pvalid;
   assign out_humidity_centi    = sd3_ff.hum;

endmodule

>>> rtl/core/env_sensor_compensation.sv
// ----------------------------------------------------------------------------
// env_sensor_compensation
// Integer compensation of raw temperature, pressure and humidity readings.
// ----------------------------------------------------------------------------
// Usage:
//   Load the six calibration registers over the csr_ port (index 0..5,
//   csr_ready is always high) while no reading is in flight. Then present
//   raw readings on the req_ channel; a beat is taken when req_valid is
//   high and req_stall is low. Each reading yields one beat on rsp_.
//   The path has 13 front stages (at most one 32x32 multiply deep each),
//   32 divider stages (one quotient bit each, the deepest section) and 3
//   correction stages. It accepts one reading per cycle while not stalled.
//   When the receiver raises rsp_stall with rsp_valid high the whole
//   pipeline holds and req_stall is raised in the same cycle, so no beat is
//   lost or repeated. Synchronous reset clears all valid bits and the
//   calibration registers to zero. A zero pressure divisor gives
//   rsp_pressure_pa of zero with rsp_pressure_valid low.
// ----------------------------------------------------------------------------
module env_sensor_compensation (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [19:0]                    req_raw_temperature,
   input  logic [19:0]                    req_raw_pressure,
   input  logic [15:0]                    req_raw_humidity,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [31:0]             rsp_temperature_centi,
   output logic [31:0]                    rsp_pressure_pa,
   output logic                           rsp_pressure_valid,
   output logic [esc_pkg::HUM_W-1:0]      rsp_humidity_centi,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [esc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [esc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   esc_pkg::cal_type  cal;
   logic              en;
   logic              fr_valid, dv_valid;
   logic [31:0]       fr_dividend, fr_divisor, dv_quotient;
   esc_pkg::side_type fr_side, dv_side;

   // hold every stage while a finished beat waits
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   esc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cal       (cal)
   );

   esc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .cal          (cal),
      .in_valid     (req_valid),
      .in_ut        (req_raw_temperature),
      .in_up        (req_raw_pressure),
      .in_uh        (req_raw_humidity),
      .out_valid    (fr_valid),
      .out_dividend (fr_dividend),
      .out_divisor  (fr_divisor),
      .out_side     (fr_side)
   );

   esc_div u_div (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (fr_valid),
      .in_dividend  (fr_dividend),
      .in_divisor   (fr_divisor),
      .in_side      (fr_side),
      .out_valid    (dv_valid),
      .out_quotient (dv_quotient),
      .out_side     (dv_side)
   );

   esc_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .en                    (en),
      .cal                   (cal),
      .in_valid              (dv_valid),
      .in_quotient           (dv_quotient),
      .in_side               (dv_side),
      .out_valid             (rsp_valid),
      .out_temperature_centi (rsp_temperature_centi),
      .out_pressure_pa       (rsp_pressure_pa),
      .out_pressure_valid    (rsp_pressure_valid),
      .out_humidity_centi    (rsp_humidity_centi)
   );

   a_invalid_press_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pressure_valid |-> rsp_pressure_pa == 32'd0)
      else $error("pressure not zeroed on zero divisor");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_humidity_centi <= 14'd10000)
      else $error("humidity above full scale");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !dv_valid && !fr_valid)
      else $error("pipeline not empty after reset");

   a_stall_holds_div: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(dv_quotient) && $stable(dv_valid))
      else $error("divider advanced during stall");

endmodule
